@@ rtl/wsg_pkg.sv @@
// ----------------------------------------------------------------------------
// Waveform sample generator package
// Shared widths, register indexes, wave codes, conversion constants and the
// quarter-wave sine function that builds the lookup ROM at elaboration.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int unsigned IndexW   = 10;
  localparam int unsigned CodeW    = 12;
  localparam int unsigned OffW     = 11;
  localparam int unsigned AmpW     = 11;
  localparam int unsigned KindW    = 2;
  localparam int unsigned DutyW    = 7;
  localparam int unsigned PeriodW  = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned MagW     = 15;

  localparam int unsigned MaxSamplesDef    = 1024;
  localparam int unsigned SinePhaseBitsDef = 12;

  // 349.24 codes per volt on centivolts is x*34924/10000 = (x*8731/4)/625.
  localparam int unsigned ConvMul     = 8731;
  localparam int unsigned Recip625    = 1717987;
  localparam int unsigned RecipShift  = 30;
  localparam int unsigned OffsetLimit = 400;
  localparam int unsigned TotalLimit  = 1100;
  localparam int unsigned DutyMax     = 100;
  localparam int unsigned Q15Bias     = 32768;
  localparam int unsigned Q15Max      = 32767;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OFFSET = 3'd0,
    REG_AMPL   = 3'd1,
    REG_KIND   = 3'd2,
    REG_DUTY   = 3'd3,
    REG_PERIOD = 3'd4
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    WAVE_SINE = 2'd0,
    WAVE_SAW  = 2'd1,
    WAVE_RECT = 2'd2,
    WAVE_RAMP = 2'd3
  } wave_e;

  typedef struct packed {
    logic             zero;
    logic             rect_lo;
    logic [CodeW-1:0] vmin;
    logic [CodeW-1:0] span;
  } meta_t;

  typedef struct packed {
    logic [CodeW-1:0] dac;
    logic             ok;
  } result_t;

  // Magnitude of the sine in Q1.15 for a reflected quarter-wave position r,
  // using a Taylor series in Q2.30 with truncating Horner steps.
  function automatic logic [MagW-1:0] sine_mag(input int unsigned r,
                                               input int unsigned qbits);
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    one = 64'd1 << 30;
    x   = (64'(r) * 64'd1686629713) >> qbits;
    x2  = (x * x) >> 30;
    t   = one;
    t   = one - (((x2 * t) >> 30) / 64'd156);
    t   = one - (((x2 * t) >> 30) / 64'd110);
    t   = one - (((x2 * t) >> 30) / 64'd72);
    t   = one - (((x2 * t) >> 30) / 64'd42);
    t   = one - (((x2 * t) >> 30) / 64'd20);
    t   = one - (((x2 * t) >> 30) / 64'd6);
    s   = (x * t) >> 30;
    v   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'(Q15Max)) begin
      v = 64'(Q15Max);
    end
    return v[MagW-1:0];
  endfunction

endpackage

@@ rtl/waveform_sample_generator_top.sv @@
// ----------------------------------------------------------------------------
// Waveform sample generator
// Turns a sample index into a 12-bit DAC code for one period of a sine,
// falling saw, rectangle or rising ramp, set up through a write port.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while no result waits in the skid entry;
// the restoring divider resolves one quotient bit per pipeline stage, so it
// sets the depth but not the rate.
// A two-entry output buffer holds the pipeline only when the consumer stalls.
// Reset is asynchronous and active low; it clears valid bits and loads the
// register defaults (offset 0, amplitude 100, sine, duty 50, period 1024).
module waveform_sample_generator_top
  import wsg_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES     = MaxSamplesDef,
  parameter int unsigned SINE_PHASE_BITS = SinePhaseBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [IndexW-1:0]   sample_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CodeW-1:0]    dac_code_o,
  output logic                ok_o
);

  localparam int unsigned QuotW    = (SINE_PHASE_BITS > CodeW) ? SINE_PHASE_BITS : CodeW;
  localparam int unsigned NumW     = ((IndexW + SINE_PHASE_BITS) > (PeriodW + CodeW)) ?
                                     (IndexW + SINE_PHASE_BITS) : (PeriodW + CodeW);
  localparam int unsigned RemW     = PeriodW;
  localparam int unsigned QuartW   = SINE_PHASE_BITS - 2;
  localparam int unsigned RomIdxW  = SINE_PHASE_BITS - 1;
  localparam int unsigned RomDepth = (2 ** QuartW) + 1;
  localparam int unsigned OffPW    = 22;
  localparam int unsigned AmpPW    = 24;
  localparam int unsigned RectW    = 18;
  localparam int unsigned ProdW    = 28;

  typedef logic [MagW-1:0] rom_t [RomDepth];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k < RomDepth; k++) begin
      rom[k] = sine_mag(k, QuartW);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  // Configuration registers.
  logic [OffW-1:0]    cfg_off_q;
  logic [AmpW-1:0]    cfg_amp_q;
  wave_e              cfg_kind_q;
  logic [DutyW-1:0]   cfg_duty_q;
  logic [PeriodW-1:0] cfg_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_off_q    <= '0;
      cfg_amp_q    <= AmpW'(100);
      cfg_kind_q   <= WAVE_SINE;
      cfg_duty_q   <= DutyW'(50);
      cfg_period_q <= PeriodW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_OFFSET: cfg_off_q    <= cfg_wdata_i[OffW-1:0];
        REG_AMPL:   cfg_amp_q    <= cfg_wdata_i[AmpW-1:0];
        REG_KIND:   cfg_kind_q   <= wave_e'(cfg_wdata_i[KindW-1:0]);
        REG_DUTY:   cfg_duty_q   <= cfg_wdata_i[DutyW-1:0];
        REG_PERIOD: cfg_period_q <= cfg_wdata_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q;
  assign en         = ~skid_v_q;
  assign in_ready_o = en;

  // Stage 1: clamp period, index and voltages, start the code conversion.
  logic [PeriodW-1:0] n_c;
  logic [IndexW-1:0]  i_c;
  logic [OffW-1:0]    off_c;
  logic [AmpW-1:0]    amp_c;
  logic [OffW:0]      off_amp_sum;

  always_comb begin
    if (cfg_period_q < PeriodW'(2)) begin
      n_c = PeriodW'(2);
    end else if (32'(cfg_period_q) > MAX_SAMPLES) begin
      n_c = PeriodW'(MAX_SAMPLES);
    end else begin
      n_c = cfg_period_q;
    end
    if (PeriodW'(sample_index_i) >= n_c) begin
      i_c = IndexW'(n_c - PeriodW'(1));
    end else begin
      i_c = sample_index_i;
    end
    off_c       = (cfg_off_q > OffW'(OffsetLimit)) ? OffW'(OffsetLimit) : cfg_off_q;
    off_amp_sum = (OffW + 1)'(off_c) + (OffW + 1)'(cfg_amp_q);
    if (off_amp_sum > (OffW + 1)'(TotalLimit)) begin
      amp_c = AmpW'(OffW'(TotalLimit) - off_c);
    end else begin
      amp_c = cfg_amp_q;
    end
  end

  logic               s1_v_q;
  logic [IndexW-1:0]  s1_i_q;
  logic [PeriodW-1:0] s1_n_q;
  logic [OffPW-1:0]   s1_offp_q;
  logic [AmpPW-1:0]   s1_ampp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_i_q    <= i_c;
      s1_n_q    <= n_c;
      s1_offp_q <= OffPW'(off_c) * OffPW'(ConvMul);
      s1_ampp_q <= AmpPW'(amp_c) * AmpPW'(ConvMul);
    end
  end

  // Stage 2: divide by 625 through a reciprocal, rectangle threshold.
  logic [43:0]      vmin_full;
  logic [43:0]      span_full;
  logic [DutyW-1:0] duty_c;
  logic [RectW-1:0] rect_lhs;
  logic [RectW-1:0] rect_rhs;
  meta_t            s2_meta_d;

  always_comb begin
    vmin_full = (44'(s1_offp_q[OffPW-1:2]) * 44'(Recip625)) >> RecipShift;
    span_full = (44'(s1_ampp_q[AmpPW-1:2]) * 44'(Recip625)) >> RecipShift;
    duty_c    = (cfg_duty_q > DutyW'(DutyMax)) ? DutyW'(DutyMax) : cfg_duty_q;
    rect_lhs  = RectW'(s1_i_q) * RectW'(DutyMax);
    rect_rhs  = RectW'(s1_n_q) * RectW'(duty_c);
    s2_meta_d.vmin    = vmin_full[CodeW-1:0];
    s2_meta_d.span    = span_full[CodeW-1:0];
    s2_meta_d.zero    = (span_full[CodeW-1:0] == '0);
    s2_meta_d.rect_lo = (rect_lhs < rect_rhs);
  end

  logic               s2_v_q;
  logic [IndexW-1:0]  s2_i_q;
  logic [PeriodW-1:0] s2_n_q;
  meta_t              s2_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_i_q    <= s1_i_q;
      s2_n_q    <= s1_n_q;
      s2_meta_q <= s2_meta_d;
    end
  end

  // Stage 3: form the dividend for the shared divider.
  logic [CodeW-1:0]       vmax;
  logic [PeriodW-1:0]     mul_a;
  logic [CodeW-1:0]       mul_b;
  logic [NumW-1:0]        num_d;

  always_comb begin
    vmax = s2_meta_q.vmin + s2_meta_q.span;
    if (cfg_kind_q == WAVE_SAW) begin
      mul_a = s2_n_q - PeriodW'(s2_i_q);
      mul_b = s2_meta_q.span;
    end else begin
      mul_a = PeriodW'(s2_i_q);
      mul_b = vmax;
    end
    if (cfg_kind_q == WAVE_SINE) begin
      num_d = NumW'(s2_i_q) << SINE_PHASE_BITS;
    end else begin
      num_d = NumW'(mul_a) * NumW'(mul_b);
    end
  end

  // Divider pipeline: one quotient bit per stage. The quotient is known to
  // fit in QuotW bits, so the top part of the dividend is already below n.
  logic               dv_v_q    [QuotW+1];
  logic [NumW-1:0]    dv_num_q  [QuotW+1];
  logic [RemW-1:0]    dv_rem_q  [QuotW+1];
  logic [QuotW-1:0]   dv_quo_q  [QuotW+1];
  logic [PeriodW-1:0] dv_n_q    [QuotW+1];
  meta_t              dv_meta_q [QuotW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_num_q[0]  <= num_d;
      dv_rem_q[0]  <= RemW'(num_d >> QuotW);
      dv_quo_q[0]  <= '0;
      dv_n_q[0]    <= s2_n_q;
      dv_meta_q[0] <= s2_meta_q;
    end
  end

  for (genvar k = 1; k <= QuotW; k++) begin : g_div
    logic [RemW:0] trial;
    logic          ge;

    always_comb begin
      trial = {dv_rem_q[k-1], dv_num_q[k-1][QuotW-k]};
      ge    = (trial >= {1'b0, dv_n_q[k-1]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (en) begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_num_q[k]  <= dv_num_q[k-1];
        dv_rem_q[k]  <= ge ? RemW'(trial - {1'b0, dv_n_q[k-1]}) : RemW'(trial);
        dv_quo_q[k]  <= {dv_quo_q[k-1][QuotW-2:0], ge};
        dv_n_q[k]    <= dv_n_q[k-1];
        dv_meta_q[k] <= dv_meta_q[k-1];
      end
    end
  end

  // Post stage 1: fold the phase onto a quarter wave and read the ROM.
  logic [SINE_PHASE_BITS-1:0] phase;
  logic [RomIdxW-1:0]         rom_idx;

  always_comb begin
    phase = dv_quo_q[QuotW][SINE_PHASE_BITS-1:0];
    if (phase[SINE_PHASE_BITS-2]) begin
      rom_idx = RomIdxW'(2 ** QuartW) - {1'b0, phase[QuartW-1:0]};
    end else begin
      rom_idx = {1'b0, phase[QuartW-1:0]};
    end
  end

  logic             p1_v_q;
  logic [MagW-1:0]  p1_mag_q;
  logic             p1_neg_q;
  logic [CodeW-1:0] p1_quo_q;
  meta_t            p1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= dv_v_q[QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_mag_q  <= SineRom[rom_idx];
      p1_neg_q  <= phase[SINE_PHASE_BITS-1];
      p1_quo_q  <= dv_quo_q[QuotW][CodeW-1:0];
      p1_meta_q <= dv_meta_q[QuotW];
    end
  end

  // Post stage 2: scale the offset sine by the span.
  logic [16:0] sine_u;

  always_comb begin
    if (p1_neg_q) begin
      sine_u = 17'(Q15Bias) - 17'(p1_mag_q);
    end else begin
      sine_u = 17'(Q15Bias) + 17'(p1_mag_q);
    end
  end

  logic             p2_v_q;
  logic [ProdW-1:0] p2_prod_q;
  logic [CodeW-1:0] p2_quo_q;
  meta_t            p2_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_prod_q <= ProdW'(sine_u[15:0]) * ProdW'(p1_meta_q.span);
      p2_quo_q  <= p1_quo_q;
      p2_meta_q <= p1_meta_q;
    end
  end

  // Final selection by wave kind.
  result_t          res;
  logic [CodeW-1:0] res_vmax;

  always_comb begin
    res_vmax = p2_meta_q.vmin + p2_meta_q.span;
    res.ok   = ~p2_meta_q.zero;
    case (cfg_kind_q)
      WAVE_SINE: res.dac = p2_meta_q.vmin + p2_prod_q[ProdW-1:16];
      WAVE_SAW:  res.dac = p2_meta_q.vmin + p2_quo_q;
      WAVE_RECT: res.dac = p2_meta_q.rect_lo ? p2_meta_q.vmin : res_vmax;
      WAVE_RAMP: res.dac = p2_quo_q;
      default:   res.dac = p2_quo_q;
    endcase
    if (p2_meta_q.zero) begin
      res.dac = '0;
    end
  end

  // Output register with one skid entry; the skid stalls the pipeline.
  logic    out_v_q;
  result_t out_q;
  result_t skid_q;
  logic    take;

  assign take = out_v_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (p2_v_q) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (p2_v_q) begin
      if (!out_v_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign dac_code_o  = out_q.dac;
  assign ok_o        = out_q.ok;

endmodule

@@ rtl/wsg_checker.sv @@
// ----------------------------------------------------------------------------
// Waveform sample generator checker
// Port-level assertions on output hold, stall behaviour and result coding.
// ----------------------------------------------------------------------------
module wsg_checker
  import wsg_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [CodeW-1:0]    dac_code_o,
  input logic                ok_o
);

  // A result that is not taken stays, with the same value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dac_code_o) && $stable(ok_o))
  else $error("output request changed while stalled");

  // Input back-pressure only appears while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
  else $error("input stalled with no result pending");

  // Once stalled, the input stays stalled until the consumer takes a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
  else $error("input stall released without output progress");

  // Settings with no span always give a zero code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> dac_code_o == '0)
  else $error("non-zero code with invalid settings");

endmodule

bind waveform_sample_generator_top wsg_checker u_wsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .dac_code_o  (dac_code_o),
  .ok_o        (ok_o)
);
